// File: sv/pgg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the point grid ground classifier.
// No dependencies; every other file depends on this package.
package pgg_pkg;

	localparam int CoordW = 19;
	localparam int BandW = 17;
	localparam int RangeW = 17;
	localparam int CellSzW = 16;
	localparam int QIdxW = 14;
	localparam int PtsW = 16;
	localparam int CfgIdxW = 4;
	localparam int CfgDataW = 19;
	// Offsets inside the window lie in (0, 2*half_range).
	localparam int OffW = RangeW + 1;
	localparam int WideW = CoordW + 2;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CENTER_X      = 4'd0,
		REG_CENTER_Y      = 4'd1,
		REG_CENTER_Z      = 4'd2,
		REG_BAND_TOP      = 4'd3,
		REG_BAND_BOTTOM   = 4'd4,
		REG_HALF_RANGE    = 4'd5,
		REG_CELL_SIZE     = 4'd6,
		REG_ORIGIN_CORNER = 4'd7
	} reg_idx_t;

	localparam logic signed [BandW-1:0] BandTopRst = 17'sd1300;
	localparam logic signed [BandW-1:0] BandBotRst = -17'sd1600;
	localparam logic [RangeW-1:0] HalfRangeRst = 17'd10000;
	localparam logic [CellSzW-1:0] CellSizeRst = 16'd200;

	typedef enum logic [8:0] {
		ST_CLR  = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_DIVS = 9'b000000100,
		ST_DIVX = 9'b000001000,
		ST_DIVY = 9'b000010000,
		ST_MUL  = 9'b000100000,
		ST_RD   = 9'b001000000,
		ST_UPD  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [QIdxW-1:0] cell_index;
		logic             inside_res;
		logic             cell_is_ground;
		logic [PtsW-1:0]  cell_points;
		logic             status;
	} result_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

// File: sv/pgg_if.sv
`timescale 1ns / 1ps
// Handshake channels of the classifier: request, result and register write.
// Depends on pgg_pkg.
interface pgg_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic signed [pgg_pkg::CoordW-1:0] point_x;
	logic signed [pgg_pkg::CoordW-1:0] point_y;
	logic signed [pgg_pkg::CoordW-1:0] point_z;
	logic                          is_ground;
	logic [pgg_pkg::QIdxW-1:0]     query_index;
	modport source (output valid, command, point_x, point_y, point_z, is_ground,
		query_index, input ready);
	modport sink (input valid, command, point_x, point_y, point_z, is_ground,
		query_index, output ready);
endinterface

interface pgg_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [pgg_pkg::QIdxW-1:0] cell_index;
	logic                      inside_res;
	logic                      cell_is_ground;
	logic [pgg_pkg::PtsW-1:0]  cell_points;
	logic                      status;
	modport source (output valid, cell_index, inside_res, cell_is_ground, cell_points,
		status, input ready);
	modport sink (input valid, cell_index, inside_res, cell_is_ground, cell_points,
		status, output ready);
endinterface

interface pgg_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pgg_pkg::CfgIdxW-1:0]  index;
	logic [pgg_pkg::CfgDataW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pgg_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on pgg_pkg.
module pgg_div #(
	parameter int N = 18,
	parameter int D = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	output pgg_pkg::div_ctl_t ctl_o,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic [N-1:0] quotient
);
	import pgg_pkg::*;

	localparam int CntW = $clog2(N + 1);

	logic [N-1:0]    quo_q;
	logic [D-1:0]    rem_q;
	logic [D-1:0]    dsr_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [D:0]      rem_sh;
	logic [D:0]      diff;
	logic            fits;

	assign rem_sh = {rem_q, quo_q[N-1]};
	assign diff = rem_sh - {1'b0, dsr_q};
	assign fits = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= (divisor == '0) ? D'(1) : divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], fits};
			rem_q <= fits ? diff[D-1:0] : rem_sh[D-1:0];
		end
	end

	assign quotient = quo_q;
	assign ctl_o.start = start;
	assign ctl_o.done = done_q;
endmodule

// File: sv/pgg_cells.sv
`timescale 1ns / 1ps
// Cell counter memory: point count and ground count per cell in one word.
// Depends on pgg_pkg.
module pgg_cells #(
	parameter int DEPTH = 16384,
	parameter int AW = 14,
	parameter int CW = 16
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [CW-1:0]   wr_points,
	input  logic [CW-1:0]   wr_ground,
	output logic [CW-1:0]   rd_points,
	output logic [CW-1:0]   rd_ground
);
	import pgg_pkg::*;

	logic [2*CW-1:0] mem [DEPTH];
	logic [2*CW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_ground, wr_points};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_points = rd_q[CW-1:0];
	assign rd_ground = rd_q[2*CW-1:CW];
endmodule

// File: sv/point_grid_ground_classifier_top.sv
`timescale 1ns / 1ps
// Point grid ground classifier: sequencer, registers, inside test and update.
// Depends on pgg_pkg, pgg_if, pgg_div and pgg_cells.

// One request at a time. An added point inside the window goes from transfer
// to result through two passes of the shared divider for column and row (18
// quotient bits each), then index multiply, memory read, update and output.
// A query within the grid reads memory and updates before output; a point
// outside, an add while the grid is empty, a query beyond the grid or a no-op
// go straight to output. A clear runs the grid-side division and then sweeps
// all MAX_SIDE*MAX_SIDE cells of the counter memory; the same sweep runs after
// reset, and no request is taken until it ends. Register writes are taken at
// any time but must only be made while no request is in flight.
module point_grid_ground_classifier_top #(
	parameter int MAX_SIDE = 128,
	parameter int COUNT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	pgg_req_if.sink   req,
	pgg_rsp_if.source rsp,
	pgg_cfg_if.sink   cfg
);
	import pgg_pkg::*;

	localparam int NCells = MAX_SIDE * MAX_SIDE;
	localparam int CellW = $clog2(NCells);
	localparam int SideW = $clog2(MAX_SIDE + 1);
	localparam int AxW = $clog2(MAX_SIDE);
	localparam logic [COUNT_BITS-1:0] CntMax = '1;

	// configuration
	logic signed [CoordW-1:0]  cx_q, cy_q, cz_q;
	logic signed [BandW-1:0]   top_q, bot_q;
	logic [RangeW-1:0]         range_q;
	logic [CellSzW-1:0]        cell_q;
	logic                      corner_q;

	state_t state_q;
	cmd_t   cmd_q;
	logic   isg_q;
	logic [OffW-1:0]  offy_q;
	logic [SideW-1:0] side_q;
	logic [AxW-1:0]   w_q, h_q;
	logic [CellW-1:0] idx_q;
	logic [CellW:0]   clr_q;
	logic             clr_res_q;
	result_t          res_q;
	result_t          out_q;
	logic             out_valid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			top_q <= BandTopRst;
			bot_q <= BandBotRst;
			range_q <= HalfRangeRst;
			cell_q <= CellSizeRst;
			corner_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CENTER_X:      cx_q <= cfg.data;
				REG_CENTER_Y:      cy_q <= cfg.data;
				REG_CENTER_Z:      cz_q <= cfg.data;
				REG_BAND_TOP:      top_q <= cfg.data[BandW-1:0];
				REG_BAND_BOTTOM:   bot_q <= cfg.data[BandW-1:0];
				REG_HALF_RANGE:    range_q <= cfg.data[RangeW-1:0];
				REG_CELL_SIZE:     cell_q <= cfg.data[CellSzW-1:0];
				REG_ORIGIN_CORNER: corner_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// inside test and offsets on the incoming point
	logic signed [WideW-1:0] x_w, y_w, z_w, cx_w, cy_w, cz_w, r_w, top_w, bot_w;
	logic signed [WideW-1:0] offx_w, offy_w;
	logic inside_c;

	always_comb begin
		x_w = WideW'(req.point_x);
		y_w = WideW'(req.point_y);
		z_w = WideW'(req.point_z);
		cx_w = WideW'(cx_q);
		cy_w = WideW'(cy_q);
		cz_w = WideW'(cz_q);
		r_w = signed'(WideW'(range_q));
		top_w = WideW'(top_q);
		bot_w = WideW'(bot_q);
		inside_c = (z_w < cz_w + top_w) && (z_w > cz_w + bot_w) &&
			(x_w < cx_w + r_w) && (x_w > cx_w - r_w) &&
			(y_w < cy_w + r_w) && (y_w > cy_w - r_w);
		if (!corner_q) begin
			offx_w = x_w - (cx_w - r_w);
			offy_w = y_w - (cy_w - r_w);
		end else begin
			offx_w = cx_w + r_w - x_w;
			offy_w = cy_w + r_w - y_w;
		end
	end

	// query range check
	logic [2*SideW-1:0] side_sq;
	logic               q_beyond;
	assign side_sq = side_q * side_q;
	assign q_beyond = (32'(req.query_index) >= 32'(side_sq)) ||
		(32'(req.query_index) >= 32'(NCells));

	logic req_xfer;
	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer = req.valid && req.ready;

	// shared divider
	logic            div_start;
	logic [OffW-1:0] div_dvd;
	logic [OffW-1:0] div_quo;
	div_ctl_t        div_ctl;

	always_comb begin
		div_start = 1'b0;
		div_dvd = offy_q;
		priority if (req_xfer && cmd_t'(req.command) == CMD_CLEAR) begin
			div_start = 1'b1;
			div_dvd = {range_q, 1'b0};
		end else if (req_xfer && cmd_t'(req.command) == CMD_ADD && inside_c &&
				side_q != '0) begin
			div_start = 1'b1;
			div_dvd = offx_w[OffW-1:0];
		end else if (state_q == ST_DIVX && div_ctl.done) begin
			div_start = 1'b1;
			div_dvd = offy_q;
		end else begin
			div_start = 1'b0;
		end
	end

	pgg_div #(.N(OffW), .D(CellSzW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_o(div_ctl),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(cell_q),
		.quotient(div_quo)
	);

	// clamp a quotient to the grid
	logic [AxW-1:0]   ax_clamp;
	logic [SideW-1:0] side_new;
	logic [SideW-1:0] side_m1;
	assign side_m1 = side_q - 1'b1;
	assign ax_clamp = (32'(div_quo) >= 32'(side_q)) ? side_m1[AxW-1:0] :
		div_quo[AxW-1:0];
	assign side_new = (32'(div_quo) >= 32'(MAX_SIDE)) ? SideW'(MAX_SIDE) :
		div_quo[SideW-1:0];

	// counter memory
	logic                  mem_rd, mem_wr;
	logic [CellW-1:0]      mem_waddr;
	logic [COUNT_BITS-1:0] wr_pts, wr_gnd, rd_pts, rd_gnd;
	logic [COUNT_BITS-1:0] n_new, g_new, n_use, g_use;
	logic [COUNT_BITS+2:0] g5, n4;
	logic                  gnd_c;
	logic [31:0]           pts_ext;
	logic [31:0]           idx_ext;

	always_comb begin
		n_new = (rd_pts == CntMax) ? rd_pts : rd_pts + 1'b1;
		g_new = (isg_q && rd_gnd != CntMax) ? rd_gnd + 1'b1 : rd_gnd;
		n_use = (cmd_q == CMD_ADD) ? n_new : rd_pts;
		g_use = (cmd_q == CMD_ADD) ? g_new : rd_gnd;
		g5 = {g_use, 2'b00} + (COUNT_BITS+3)'(g_use);
		n4 = {1'b0, n_use, 2'b00};
		gnd_c = (n_use != '0) && (g5 > n4);
		pts_ext = 32'(n_use);
		idx_ext = 32'(idx_q);
		mem_rd = (state_q == ST_RD);
		mem_wr = 1'b0;
		mem_waddr = idx_q;
		wr_pts = n_new;
		wr_gnd = g_new;
		if (state_q == ST_CLR) begin
			mem_wr = 1'b1;
			mem_waddr = clr_q[CellW-1:0];
			wr_pts = '0;
			wr_gnd = '0;
		end else if (state_q == ST_UPD && cmd_q == CMD_ADD) begin
			mem_wr = 1'b1;
		end
	end

	pgg_cells #(.DEPTH(NCells), .AW(CellW), .CW(COUNT_BITS)) u_cells (
		.clk(clk),
		.rd_en(mem_rd),
		.rd_addr(idx_q),
		.wr_en(mem_wr),
		.wr_addr(mem_waddr),
		.wr_points(wr_pts),
		.wr_ground(wr_gnd),
		.rd_points(rd_pts),
		.rd_ground(rd_gnd)
	);

	logic out_free;
	assign out_free = !out_valid_q || rsp.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			clr_res_q <= 1'b0;
			side_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise on a finished request, drop once the result is taken
			out_valid_q <= (state_q == ST_DONE && out_free) ? 1'b1 :
				(rsp.ready ? 1'b0 : out_valid_q);
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						unique case (cmd_t'(req.command))
							CMD_CLEAR: state_q <= ST_DIVS;
							CMD_ADD: state_q <= (inside_c && side_q != '0) ? ST_DIVX : ST_DONE;
							CMD_QUERY: state_q <= q_beyond ? ST_DONE : ST_RD;
							CMD_NOP: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DIVS: begin
					if (div_ctl.done) begin
						side_q <= side_new;
						clr_q <= '0;
						clr_res_q <= 1'b1;
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (CellW+1)'(NCells - 1)) begin
						state_q <= clr_res_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_DIVX: if (div_ctl.done) state_q <= ST_DIVY;
				ST_DIVY: if (div_ctl.done) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_RD;
				ST_RD:   state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			cmd_q <= cmd_t'(req.command);
			isg_q <= req.is_ground;
			offy_q <= offy_w[OffW-1:0];
			idx_q <= CellW'(req.query_index);
			res_q <= '{
				cell_index: (cmd_t'(req.command) == CMD_QUERY && q_beyond) ?
					req.query_index : '0,
				inside_res: (cmd_t'(req.command) == CMD_ADD) && inside_c,
				cell_is_ground: 1'b0,
				cell_points: '0,
				status: (cmd_t'(req.command) == CMD_QUERY) && q_beyond
			};
		end
		if (state_q == ST_DIVX && div_ctl.done) begin
			w_q <= ax_clamp;
		end
		if (state_q == ST_DIVY && div_ctl.done) begin
			h_q <= ax_clamp;
		end
		if (state_q == ST_MUL) begin
			idx_q <= CellW'(32'(w_q) + 32'(side_q) * 32'(h_q));
		end
		if (state_q == ST_UPD) begin
			res_q <= '{
				cell_index: idx_ext[QIdxW-1:0],
				inside_res: (cmd_q == CMD_ADD),
				cell_is_ground: gnd_c,
				cell_points: pts_ext[PtsW-1:0],
				status: 1'b0
			};
		end
		if (state_q == ST_DIVS) begin
			res_q <= '0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.cell_index = out_q.cell_index;
	assign rsp.inside_res = out_q.inside_res;
	assign rsp.cell_is_ground = out_q.cell_is_ground;
	assign rsp.cell_points = out_q.cell_points;
	assign rsp.status = out_q.status;
endmodule

// File: sv/pgg_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the classifier, bound to the top level.
// Depends on pgg_pkg and the top level's interface ports.
module pgg_chk (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [pgg_pkg::QIdxW-1:0] rsp_cell_index,
	input logic rsp_inside_res,
	input logic rsp_cell_is_ground,
	input logic [pgg_pkg::PtsW-1:0] rsp_cell_points,
	input logic rsp_status
);
	import pgg_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_index))
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_beyond_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> !rsp_inside_res && !rsp_cell_is_ground &&
			rsp_cell_points == '0)
		else $error("beyond-grid result carries cell data");

	a_ground_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_cell_is_ground |-> rsp_cell_points != '0)
		else $error("empty cell marked ground");
endmodule

bind point_grid_ground_classifier_top pgg_chk u_pgg_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_cell_index(rsp.cell_index),
	.rsp_inside_res(rsp.inside_res),
	.rsp_cell_is_ground(rsp.cell_is_ground),
	.rsp_cell_points(rsp.cell_points),
	.rsp_status(rsp.status)
);
